>>> rtl/pn3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared constants, item codes and stage control types of the 3D noise sampler.
// ----------------------------------------------------------------------------
package pn3d_pkg;

    localparam int FRAC_W     = 16;                // fraction bits of a coordinate
    localparam int IDX_W      = 8;                 // table index width
    localparam int TABLE_SIZE = 1 << IDX_W;
    localparam int GRAD_W     = 16;                // one gradient component
    localparam int PERM_W     = 8;
    localparam int DOT_W      = 20;                // dot product and blend values
    localparam int OUT_W      = 19;
    localparam int NUM_STG    = 9;                 // stage 9 is the output register

    localparam logic signed [DOT_W-1:0] OUT_MAX = DOT_W'(262143);
    localparam logic signed [DOT_W-1:0] OUT_MIN = -DOT_W'(262144);

    typedef enum logic [1:0] {
        MODE_GRAD   = 2'd0,
        MODE_PERM   = 2'd1,
        MODE_SAMPLE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [NUM_STG:1] en;    // stage k loads at this edge
        logic [NUM_STG:1] v;     // stage k holds a word
        logic [1:0]       mode1;
        logic [1:0]       mode2;
    } t_ctl;

    typedef struct packed {
        logic [IDX_W-1:0]             idx;
        logic [2:0][GRAD_W-1:0]       grad;
        logic [2:0][FRAC_W-1:0]       frac;
        logic [2:0][PERM_W-1:0]       pv0;   // entry at the floor lattice index
        logic [2:0][PERM_W-1:0]       pv1;   // entry at floor + 1
    } t_s2;

endpackage

>>> rtl/perlin_noise_3d_sample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_sample
// 3D gradient noise sampler with loadable gradient and permutation tables.
// ----------------------------------------------------------------------------
// Accepts one word per clock while o_ready is high. A sample's noise value
// shows on the output with o_valid and stays there until i_ready takes it.
// A word passes through the nine register stages: input, permutation read,
// gradient read, products, sum, scale, then one blend per axis; the four
// chained multiplies of the fade weight run beside the table-read and
// dot-product stages. Load words write their table as they pass the stage
// that reads that table and produce no output, so loads and samples take
// effect in their accepted order. Every stage stalls on its own, so bubbles
// fill while a result waits at the output.
// ----------------------------------------------------------------------------
module perlin_noise_3d_sample
    import pn3d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic [IDX_W-1:0]         i_table_index,
    input  logic [1:0]               i_axis_select,
    input  logic [PERM_W-1:0]        i_perm_value,
    input  logic signed [GRAD_W-1:0] i_gradient_x,
    input  logic signed [GRAD_W-1:0] i_gradient_y,
    input  logic signed [GRAD_W-1:0] i_gradient_z,
    input  logic signed [31:0]       i_point_x,
    input  logic signed [31:0]       i_point_y,
    input  logic signed [31:0]       i_point_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_noise_value
);

    logic [NUM_STG:1]       r_v;
    logic [1:0]             r_mode1, r_mode2;
    logic [NUM_STG:1]       en;
    t_ctl                   ctl;
    logic [2:0][FRAC_W-1:0] frac1;
    t_s2                    s2;
    logic [7:0][DOT_W-1:0]  dot;
    logic [2:0][FRAC_W:0]   w;

    always_comb begin
        en[NUM_STG] = !r_v[NUM_STG] || i_ready;
        for (int k = NUM_STG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_mode1 <= '0;
            r_mode2 <= '0;
        end else begin
            if (en[1]) begin
                r_v[1]  <= i_valid;
                r_mode1 <= i_mode;
            end
            if (en[2]) begin
                r_v[2]  <= r_v[1];
                r_mode2 <= r_mode1;
            end
            // drop load words once their table is written
            if (en[3]) begin
                r_v[3] <= r_v[2] && (r_mode2 == MODE_SAMPLE);
            end
            for (int k = 4; k <= NUM_STG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign ctl.en    = en;
    assign ctl.v     = r_v;
    assign ctl.mode1 = r_mode1;
    assign ctl.mode2 = r_mode2;

    pn3d_lattice u_lattice (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_table_index (i_table_index),
        .i_axis_select (i_axis_select),
        .i_perm_value  (i_perm_value),
        .i_gradient_x  (i_gradient_x),
        .i_gradient_y  (i_gradient_y),
        .i_gradient_z  (i_gradient_z),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_frac1       (frac1),
        .o_s2          (s2)
    );

    pn3d_corner u_corner (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_s2  (s2),
        .o_dot (dot)
    );

    pn3d_fade u_fade (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_frac1 (frac1),
        .o_w     (w)
    );

    pn3d_blend u_blend (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_dot         (dot),
        .i_w           (w),
        .o_noise_value (o_noise_value)
    );

    assign o_ready = en[1];
    assign o_valid = r_v[NUM_STG];

endmodule

>>> rtl/pn3d_lattice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_lattice
// Input register, lattice split and the three per-axis permutation tables.
// ----------------------------------------------------------------------------
module pn3d_lattice
    import pn3d_pkg::*;
(
    input  logic                       i_clk,
    input  t_ctl                       i_ctl,
    input  logic [IDX_W-1:0]           i_table_index,
    input  logic [1:0]                 i_axis_select,
    input  logic [PERM_W-1:0]          i_perm_value,
    input  logic signed [GRAD_W-1:0]   i_gradient_x,
    input  logic signed [GRAD_W-1:0]   i_gradient_y,
    input  logic signed [GRAD_W-1:0]   i_gradient_z,
    input  logic signed [31:0]         i_point_x,
    input  logic signed [31:0]         i_point_y,
    input  logic signed [31:0]         i_point_z,
    output logic [2:0][FRAC_W-1:0]     o_frac1,
    output t_s2                        o_s2
);

    logic [IDX_W-1:0]        r_idx;
    logic [1:0]              r_axis;
    logic [PERM_W-1:0]       r_pval;
    logic [2:0][GRAD_W-1:0]  r_grad;
    logic [2:0][IDX_W-1:0]   r_base;
    logic [2:0][FRAC_W-1:0]  r_frac;
    t_s2                     r_s2;
    logic                    perm_we;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_idx     <= i_table_index;
            r_axis    <= i_axis_select;
            r_pval    <= i_perm_value;
            r_grad[0] <= i_gradient_x;
            r_grad[1] <= i_gradient_y;
            r_grad[2] <= i_gradient_z;
            r_base[0] <= i_point_x[FRAC_W +: IDX_W];
            r_base[1] <= i_point_y[FRAC_W +: IDX_W];
            r_base[2] <= i_point_z[FRAC_W +: IDX_W];
            r_frac[0] <= i_point_x[FRAC_W-1:0];
            r_frac[1] <= i_point_y[FRAC_W-1:0];
            r_frac[2] <= i_point_z[FRAC_W-1:0];
        end
    end

    assign perm_we = i_ctl.v[1] && (i_ctl.mode1 == MODE_PERM) && i_ctl.en[2];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [PERM_W-1:0] mem [TABLE_SIZE];
        logic [IDX_W-1:0]  idx_far;

        assign idx_far = r_base[a] + IDX_W'(1);

        always_ff @(posedge i_clk) begin
            if (perm_we && (r_axis == 2'(a))) begin
                mem[r_idx] <= r_pval;
            end
            if (i_ctl.en[2]) begin
                r_s2.pv0[a] <= mem[r_base[a]];
                r_s2.pv1[a] <= mem[idx_far];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s2.idx  <= r_idx;
            r_s2.grad <= r_grad;
            r_s2.frac <= r_frac;
        end
    end

    assign o_frac1 = r_frac;
    assign o_s2    = r_s2;

endmodule

>>> rtl/pn3d_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_corner
// Gradient lookup for the eight cell corners and their dot products.
// ----------------------------------------------------------------------------
module pn3d_corner
    import pn3d_pkg::*;
(
    input  logic                          i_clk,
    input  t_ctl                          i_ctl,
    input  t_s2                           i_s2,
    output logic [7:0][DOT_W-1:0]         o_dot
);

    logic [7:0][IDX_W-1:0]             gi;
    logic [7:0][3*GRAD_W-1:0]          r_grad;
    logic [2:0][FRAC_W-1:0]            r_frac3;
    logic [7:0][2:0][GRAD_W+FRAC_W:0]  r_prod;
    logic [7:0][GRAD_W+FRAC_W+2:0]     r_acc;
    logic [7:0][DOT_W-1:0]             r_dot;
    logic                              grad_we;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            gi[c] = (c[0] ? i_s2.pv1[0] : i_s2.pv0[0])
                  ^ (c[1] ? i_s2.pv1[1] : i_s2.pv0[1])
                  ^ (c[2] ? i_s2.pv1[2] : i_s2.pv0[2]);
        end
    end

    assign grad_we = i_ctl.v[2] && (i_ctl.mode2 == MODE_GRAD) && i_ctl.en[3];

    // four copies of the gradient table, two corners read from each
    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [3*GRAD_W-1:0] mem [TABLE_SIZE];

        always_ff @(posedge i_clk) begin
            if (grad_we) begin
                mem[i_s2.idx] <= {i_s2.grad[2], i_s2.grad[1], i_s2.grad[0]};
            end
            if (i_ctl.en[3]) begin
                r_grad[2*k]   <= mem[gi[2*k]];
                r_grad[2*k+1] <= mem[gi[2*k+1]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_frac3 <= i_s2.frac;
        end
    end

    // far corner offset t - 1 is the fraction with a sign bit set
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            for (int c = 0; c < 8; c++) begin
                for (int a = 0; a < 3; a++) begin
                    r_prod[c][a] <= $signed(r_grad[c][a*GRAD_W +: GRAD_W])
                                  * $signed({c[a], r_frac3[a]});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            for (int c = 0; c < 8; c++) begin
                r_acc[c] <= $signed(r_prod[c][0]) + $signed(r_prod[c][1])
                          + $signed(r_prod[c][2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            for (int c = 0; c < 8; c++) begin
                r_dot[c] <= r_acc[c][15 +: DOT_W];
            end
        end
    end

    assign o_dot = r_dot;

endmodule

>>> rtl/pn3d_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_fade
// Quintic fade weight 6t^5 - 15t^4 + 10t^3, one multiply per stage.
// ----------------------------------------------------------------------------
module pn3d_fade
    import pn3d_pkg::*;
(
    input  logic                      i_clk,
    input  t_ctl                      i_ctl,
    input  logic [2:0][FRAC_W-1:0]    i_frac1,
    output logic [2:0][FRAC_W:0]      o_w
);

    localparam int PW = 40;
    localparam int AW = 22;
    localparam logic signed [AW-1:0] ONE_FX = AW'(1 << FRAC_W);

    logic [2:0][FRAC_W-1:0]   r_t2, r_t3, r_t4;
    logic [2:0][PW-1:0]       r_p1, r_p2, r_p3, r_p4;
    logic [2:0][FRAC_W:0]     r_w;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [AW-1:0] u, ca, cb, cc, cw;
        logic signed [FRAC_W:0] t1, t2, t3, t4;

        assign t1 = $signed({1'b0, i_frac1[a]});
        assign t2 = $signed({1'b0, r_t2[a]});
        assign t3 = $signed({1'b0, r_t3[a]});
        assign t4 = $signed({1'b0, r_t4[a]});
        assign u  = AW'(6) * AW'(t1) - AW'(15) * ONE_FX;
        assign ca = $signed(r_p1[a][FRAC_W +: AW]) + AW'(10) * ONE_FX;
        assign cb = $signed(r_p2[a][FRAC_W +: AW]);
        assign cc = $signed(r_p3[a][FRAC_W +: AW]);
        assign cw = $signed(r_p4[a][FRAC_W +: AW]);

        always_ff @(posedge i_clk) begin
            if (i_ctl.en[2]) begin
                r_t2[a] <= i_frac1[a];
                r_p1[a] <= t1 * u;
            end
            if (i_ctl.en[3]) begin
                r_t3[a] <= r_t2[a];
                r_p2[a] <= t2 * ca;
            end
            if (i_ctl.en[4]) begin
                r_t4[a] <= r_t3[a];
                r_p3[a] <= t3 * cb;
            end
            if (i_ctl.en[5]) begin
                r_p4[a] <= t4 * cc;
            end
            if (i_ctl.en[6]) begin
                if (cw < 0) begin
                    r_w[a] <= '0;
                end else if (cw > ONE_FX) begin
                    r_w[a] <= ONE_FX[FRAC_W:0];
                end else begin
                    r_w[a] <= cw[FRAC_W:0];
                end
            end
        end
    end

    assign o_w = r_w;

endmodule

>>> rtl/pn3d_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_blend
// Trilinear blend of the corner dot products, x then y then z, and saturation.
// ----------------------------------------------------------------------------
module pn3d_blend
    import pn3d_pkg::*;
(
    input  logic                         i_clk,
    input  t_ctl                         i_ctl,
    input  logic [7:0][DOT_W-1:0]        i_dot,
    input  logic [2:0][FRAC_W:0]         i_w,
    output logic signed [OUT_W-1:0]      o_noise_value
);

    localparam int BW = 40;

    logic [3:0][DOT_W-1:0]  r_x;
    logic [1:0][DOT_W-1:0]  r_y;
    logic [FRAC_W:0]        r_wy7, r_wz7, r_wz8;
    logic [OUT_W-1:0]       r_out;
    logic signed [DOT_W-1:0] zr;

    function automatic logic [DOT_W-1:0] lerp(input logic [DOT_W-1:0] lo,
                                              input logic [DOT_W-1:0] hi,
                                              input logic [FRAC_W:0]  w);
        logic [FRAC_W:0]      om;
        logic signed [BW-1:0] s;
        om = (FRAC_W+1)'(1 << FRAC_W) - w;
        s  = $signed({1'b0, om}) * $signed(lo) + $signed({1'b0, w}) * $signed(hi);
        return s[FRAC_W +: DOT_W];
    endfunction

    assign zr = $signed(lerp(r_y[0], r_y[1], r_wz8));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[7]) begin
            for (int k = 0; k < 4; k++) begin
                r_x[k] <= lerp(i_dot[2*k], i_dot[2*k+1], i_w[0]);
            end
            r_wy7 <= i_w[1];
            r_wz7 <= i_w[2];
        end
        if (i_ctl.en[8]) begin
            r_y[0] <= lerp(r_x[0], r_x[1], r_wy7);
            r_y[1] <= lerp(r_x[2], r_x[3], r_wy7);
            r_wz8  <= r_wz7;
        end
        if (i_ctl.en[9]) begin
            if (zr > OUT_MAX) begin
                r_out <= OUT_MAX[OUT_W-1:0];
            end else if (zr < OUT_MIN) begin
                r_out <= OUT_MIN[OUT_W-1:0];
            end else begin
                r_out <= zr[OUT_W-1:0];
            end
        end
    end

    assign o_noise_value = r_out;

endmodule
